// ----- hw/rtl/mpq_pkg.sv -----
// Package for the minimum priority queue: operation and status codes, field widths.
// No dependencies.
package mpq_pkg;

	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 5;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

// ----- hw/rtl/min_priority_queue_array.sv -----
// Top level of the minimum priority queue kept as an unsorted array.
// Depends on mpq_pkg and mpq_ram.
//
// Usage:
//   Drive func and value and raise start; the word is taken at a clock edge
//   where start is high and busy is low. Each word yields exactly one result,
//   shown on status, data and count for one cycle while done is high. The
//   receiver cannot stall, so the result must be captured in that cycle.
//   Insert: appends value at the end of the store, or reports full.
//   Remove: scans the store for the smallest signed value (first on ties),
//   returns it and shifts later entries down one place.
//   Peek: scans the same way and changes nothing.
// Sequencing:
//   insert, full, empty or unused code: done in the cycle after acceptance,
//   busy stays low.
//   peek: a scan over every entry, then done.
//   remove: the same scan, then a shift of the entries after the minimum.
//   All of it runs through one read port of the store and one signed comparator.
// Reset: the occupancy clears, though the count output register does not; store
//   contents are left as they are, and only entries below the occupancy are ever read.
module min_priority_queue_array
	import mpq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [FUNC_W-1:0]          func,
	input  logic signed [DATA_W-1:0]   value,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic signed [DATA_W-1:0]   data,
	output logic [COUNT_W-1:0]         count
);

	localparam int AW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t                     state_q;
	logic [OW-1:0]              occ_q;
	logic [FUNC_W-1:0]          func_q;
	logic [OW-1:0]              rd_ptr_q;   // next store address to read
	logic                       ret_vld_q;  // read data arrives this cycle
	logic [AW-1:0]              ret_idx_q;  // address of the arriving data
	logic signed [DATA_W-1:0]   best_q;
	logic [AW-1:0]              best_idx_q;
	logic                       done_q;
	logic [STATUS_W-1:0]        status_q;
	logic signed [DATA_W-1:0]   data_q;
	logic [COUNT_W-1:0]         count_q;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [DATA_W-1:0]          ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [DATA_W-1:0]          ram_rdata;

	logic                       issue;
	logic                       take;
	logic signed [DATA_W-1:0]   best_nxt;
	logic [AW-1:0]              best_idx_nxt;
	logic                       full;

	mpq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign full  = (occ_q == OW'(DEPTH));
	assign issue = (rd_ptr_q < occ_q);

	// Shared comparator: first arriving entry seeds the minimum, a later one
	// replaces it only when strictly smaller, which keeps the first on ties.
	assign take         = ret_vld_q && ((ret_idx_q == '0) || ($signed(ram_rdata) < best_q));
	assign best_nxt     = take ? $signed(ram_rdata) : best_q;
	assign best_idx_nxt = take ? ret_idx_q : best_idx_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = occ_q[AW-1:0];
		ram_wdata = value;
		ram_raddr = rd_ptr_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				// append at the end of the store
				if (start && (func == FUNC_INSERT) && !full) begin
					ram_we = 1'b1;
				end
			end
			S_SHIFT: begin
				// move the arriving entry down one place
				if (ret_vld_q) begin
					ram_we    = 1'b1;
					ram_waddr = ret_idx_q - AW'(1);
					ram_wdata = ram_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			ret_vld_q <= 1'b0;
			done_q    <= 1'b0;
			rd_ptr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q <= func;
						data_q <= '0;
						case (func)
							FUNC_INSERT: begin
								done_q <= 1'b1;
								if (full) begin
									status_q <= STATUS_FULL;
									count_q  <= COUNT_W'(occ_q);
								end else begin
									status_q <= STATUS_OK;
									occ_q    <= occ_q + OW'(1);
									count_q  <= COUNT_W'(occ_q + OW'(1));
								end
							end
							FUNC_REMOVE, FUNC_PEEK: begin
								if (occ_q == '0) begin
									done_q   <= 1'b1;
									status_q <= STATUS_EMPTY;
									count_q  <= '0;
								end else begin
									state_q   <= S_SCAN;
									rd_ptr_q  <= '0;
									ret_vld_q <= 1'b0;
								end
							end
							default: begin
								// unused code: no operation
								done_q   <= 1'b1;
								status_q <= STATUS_OK;
								count_q  <= COUNT_W'(occ_q);
							end
						endcase
					end
				end
				S_SCAN: begin
					ret_vld_q  <= issue;
					ret_idx_q  <= rd_ptr_q[AW-1:0];
					best_q     <= best_nxt;
					best_idx_q <= best_idx_nxt;
					if (issue) begin
						rd_ptr_q <= rd_ptr_q + OW'(1);
					end else if (func_q == FUNC_PEEK) begin
						// last entry compared: report the minimum
						done_q    <= 1'b1;
						status_q  <= STATUS_OK;
						data_q    <= best_nxt;
						count_q   <= COUNT_W'(occ_q);
						ret_vld_q <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						// start closing the gap from the entry after the minimum
						rd_ptr_q  <= OW'(best_idx_nxt) + OW'(1);
						ret_vld_q <= 1'b0;
						state_q   <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					ret_vld_q <= issue;
					ret_idx_q <= rd_ptr_q[AW-1:0];
					if (issue) begin
						rd_ptr_q <= rd_ptr_q + OW'(1);
					end else begin
						// last move, if any, is written this cycle
						occ_q     <= occ_q - OW'(1);
						done_q    <= 1'b1;
						status_q  <= STATUS_OK;
						data_q    <= best_q;
						count_q   <= COUNT_W'(occ_q - OW'(1));
						ret_vld_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign data   = data_q;
	assign count  = count_q;

endmodule

// ----- hw/rtl/mpq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
